/* sv/spa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared constants, size-class tables and controller/datapath structs.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int NUM_CLASSES  = 9;
    localparam int TOTAL_BLOCKS = 600;
    localparam int ADDR_BITS    = 48;
    localparam int REGION_BYTES = 243712;

    localparam int CLS_W  = 4;
    localparam int LINK_W = 9;
    localparam int BLK_W  = 10;
    localparam int OFF_W  = 18;
    localparam int SIZE_W = 16;
    localparam int MEM_W  = LINK_W + 1;

    // largest class: 4480 bytes = 35 * 128
    localparam int BIG_CLASS = 8;
    localparam int BIG_SHIFT = 7;
    localparam int BIG_MUL   = 35;
    localparam int BIG_RECIP = 235;
    localparam int BIG_RSH   = 13;

    typedef enum logic [2:0] {
        ST_ALLOCATED  = 3'd0,
        ST_FREED      = 3'd1,
        ST_NO_FIT     = 3'd2,
        ST_POOL_EMPTY = 3'd3,
        ST_IGNORED    = 3'd4,
        ST_MISALIGNED = 3'd5,
        ST_DOUBLE     = 3'd6
    } status_t;

    localparam logic OP_ALLOC = 1'b0;

    typedef struct packed {
        logic init_en;
        logic load;
        logic calc1;
        logic calc2;
        logic read;
        logic commit;
    } spa_cmd_t;

    typedef struct packed {
        logic init_done;
    } spa_stat_t;

    function automatic logic [12:0] class_size(input logic [CLS_W-1:0] c);
        logic [12:0] r;
        unique case (c)
            4'd0:    r = 13'd16;
            4'd1:    r = 13'd32;
            4'd2:    r = 13'd64;
            4'd3:    r = 13'd128;
            4'd4:    r = 13'd256;
            4'd5:    r = 13'd512;
            4'd6:    r = 13'd1024;
            4'd7:    r = 13'd2048;
            default: r = 13'd4480;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] class_shift(input logic [CLS_W-1:0] c);
        return 4'(c + 4'd4);
    endfunction

    function automatic logic [LINK_W-1:0] class_count(input logic [CLS_W-1:0] c);
        logic [LINK_W-1:0] r;
        unique case (c)
            4'd0:    r = 9'd256;
            4'd1:    r = 9'd128;
            4'd2:    r = 9'd64;
            4'd3:    r = 9'd32;
            4'd4:    r = 9'd16;
            4'd5:    r = 9'd8;
            4'd6:    r = 9'd16;
            4'd7:    r = 9'd64;
            default: r = 9'd16;
        endcase
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] pool_offset(input logic [CLS_W-1:0] c);
        logic [OFF_W-1:0] r;
        unique case (c)
            4'd0:    r = 18'd0;
            4'd1:    r = 18'd4096;
            4'd2:    r = 18'd8192;
            4'd3:    r = 18'd12288;
            4'd4:    r = 18'd16384;
            4'd5:    r = 18'd20480;
            4'd6:    r = 18'd24576;
            4'd7:    r = 18'd40960;
            default: r = 18'd172032;
        endcase
        return r;
    endfunction

    function automatic logic [BLK_W-1:0] pool_first(input logic [CLS_W-1:0] c);
        logic [BLK_W-1:0] r;
        unique case (c)
            4'd0:    r = 10'd0;
            4'd1:    r = 10'd256;
            4'd2:    r = 10'd384;
            4'd3:    r = 10'd448;
            4'd4:    r = 10'd480;
            4'd5:    r = 10'd496;
            4'd6:    r = 10'd504;
            4'd7:    r = 10'd520;
            default: r = 10'd584;
        endcase
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] pool_end(input logic [CLS_W-1:0] c);
        logic [OFF_W-1:0] r;
        unique case (c)
            4'd0:    r = 18'd4096;
            4'd1:    r = 18'd8192;
            4'd2:    r = 18'd12288;
            4'd3:    r = 18'd16384;
            4'd4:    r = 18'd20480;
            4'd5:    r = 18'd24576;
            4'd6:    r = 18'd40960;
            4'd7:    r = 18'd172032;
            default: r = 18'd243712;
        endcase
        return r;
    endfunction

endpackage

/* sv/spa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ctrl
// Request sequencer: link memory set-up, request steps and result handshake.
// ----------------------------------------------------------------------------
module spa_ctrl
    import spa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  spa_stat_t stat,
    output spa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_CALC1, S_CALC2, S_READ, S_EXEC
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = s_ready_reg;
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.init_en = (state_reg == S_INIT);
        cmd.load    = (state_reg == S_IDLE) && s_valid && s_ready_reg;
        cmd.calc1   = (state_reg == S_CALC1);
        cmd.calc2   = (state_reg == S_CALC2);
        cmd.read    = (state_reg == S_READ);
        cmd.commit  = (state_reg == S_EXEC) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    if (stat.init_done) begin
                        state_reg   <= S_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= S_CALC1;
                        s_ready_reg <= 1'b0;
                    end
                end
                S_CALC1: state_reg <= S_CALC2;
                S_CALC2: state_reg <= S_READ;
                S_READ:  state_reg <= S_EXEC;
                S_EXEC: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        s_ready_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_INIT;
            endcase
        end
    end

endmodule

/* sv/spa_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_dpath
// Class selection, pool lookup, link memory, free-list heads and result regs.
// ----------------------------------------------------------------------------
module spa_dpath
    import spa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spa_cmd_t             cmd,
    output spa_stat_t            stat,
    input  logic [ADDR_BITS-1:0] region_base,
    input  logic                 s_operation,
    input  logic [SIZE_W-1:0]    s_request_size,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic [2:0]           m_status,
    output logic [ADDR_BITS-1:0] m_block_address,
    output logic [CLS_W-1:0]     m_pool_index
);

    // link memory: bit 9 free mark, bits 8:0 next local index
    logic [MEM_W-1:0] mem [TOTAL_BLOCKS];

    logic [LINK_W-1:0] head_reg [NUM_CLASSES];
    logic [LINK_W-1:0] left_reg [NUM_CLASSES];

    logic [BLK_W-1:0]  init_g_reg;
    logic [CLS_W-1:0]  init_cls_reg;
    logic [LINK_W-1:0] init_loc_reg;

    logic                 op_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] off_reg;
    logic                 null_reg, nofit_reg, empty_reg, inrange_reg, low_ok_reg;
    logic [CLS_W-1:0]     cls_reg;
    logic [LINK_W-1:0]    local_reg;
    logic [BLK_W-1:0]     g_reg;
    logic [OFF_W-1:0]     rel_reg;
    logic [9:0]           q_reg;
    logic [4:0]           k_reg;
    logic [MEM_W-1:0]     rdata_reg;

    logic [2:0]           status_reg;
    logic [ADDR_BITS-1:0] baddr_reg;
    logic [CLS_W-1:0]     pidx_reg;

    logic [CLS_W-1:0]  cls_a;
    logic              fit_a;
    logic [CLS_W-1:0]  cls_f;
    logic [OFF_W-1:0]  loc_off;
    logic [LINK_W-1:0] head_c;
    logic [OFF_W-1:0]  head_bytes;
    logic [LINK_W-1:0] local_c;
    logic              low_ok_c;
    logic [9:0]        q_c;
    logic [4:0]        k_c;
    logic [17:0]       kmul;
    logic [BLK_W-1:0]  g_c;
    logic [BLK_W-1:0]  g_sel;
    logic              aligned;
    logic [LINK_W-1:0] init_next;

    assign stat.init_done = cmd.init_en && (init_g_reg == BLK_W'(TOTAL_BLOCKS - 1));
    assign init_next      = init_loc_reg + 1'b1;

    // smallest class that fits the request
    always_comb begin
        cls_a = '0;
        fit_a = 1'b0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (SIZE_W'(class_size(CLS_W'(i))) >= size_reg) begin
                cls_a = CLS_W'(i);
                fit_a = 1'b1;
            end
        end
    end

    // pool that holds the offset
    always_comb begin
        cls_f = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (off_reg[OFF_W-1:0] < pool_end(CLS_W'(i))) begin
                cls_f = CLS_W'(i);
            end
        end
    end

    always_comb begin
        head_c = head_reg[cls_reg];
        if (cls_reg == CLS_W'(BIG_CLASS)) begin
            head_bytes = OFF_W'(OFF_W'(head_c) * OFF_W'(BIG_MUL)) << BIG_SHIFT;
        end else begin
            head_bytes = OFF_W'(head_c) << class_shift(cls_reg);
        end
    end

    always_comb begin
        loc_off = off_reg[OFF_W-1:0] - pool_offset(cls_f);
        q_c     = loc_off[16:7];
        kmul    = 18'(q_c * 8'(BIG_RECIP));
        k_c     = kmul[BIG_RSH +: 5];
        if (cls_f == CLS_W'(BIG_CLASS)) begin
            low_ok_c = (loc_off[BIG_SHIFT-1:0] == '0);
            local_c  = LINK_W'(k_c);
        end else begin
            low_ok_c = ((loc_off & ((OFF_W'(1) << class_shift(cls_f)) - 1'b1)) == '0);
            local_c  = LINK_W'(loc_off >> class_shift(cls_f));
        end
        g_c = pool_first(cls_f) + BLK_W'(local_c);
    end

    assign g_sel   = (op_reg == OP_ALLOC) ? pool_first(cls_reg) + BLK_W'(head_c) : g_c;
    assign aligned = low_ok_reg &&
                     ((cls_reg != CLS_W'(BIG_CLASS)) || (10'(k_reg * 6'(BIG_MUL)) == q_reg));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            size_reg <= s_request_size;
            addr_reg <= s_address;
        end
        if (cmd.calc1) begin
            off_reg   <= addr_reg - region_base;
            null_reg  <= (addr_reg == '0);
            nofit_reg <= !fit_a;
            cls_reg   <= cls_a;
        end
        if (cmd.calc2) begin
            if (op_reg == OP_ALLOC) begin
                empty_reg <= (left_reg[cls_reg] == '0);
                rel_reg   <= pool_offset(cls_reg) + head_bytes;
                local_reg <= head_c;
            end else begin
                cls_reg     <= cls_f;
                inrange_reg <= (off_reg < ADDR_BITS'(REGION_BYTES));
                low_ok_reg  <= low_ok_c;
                local_reg   <= local_c;
                q_reg       <= q_c;
                k_reg       <= k_c;
            end
            g_reg <= (g_sel < BLK_W'(TOTAL_BLOCKS)) ? g_sel : '0;
        end
    end

    // link memory
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rdata_reg <= mem[g_reg];
        end
        if (cmd.init_en) begin
            mem[init_g_reg] <= {1'b1, init_next};
        end else if (cmd.commit) begin
            if (op_reg == OP_ALLOC) begin
                if (!nofit_reg && !empty_reg) begin
                    mem[g_reg] <= {1'b0, rdata_reg[LINK_W-1:0]};
                end
            end else if (!null_reg && inrange_reg && aligned && !rdata_reg[LINK_W]) begin
                mem[g_reg] <= {1'b1, head_reg[cls_reg]};
            end
        end
    end

    // set-up sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_g_reg   <= '0;
            init_cls_reg <= '0;
            init_loc_reg <= '0;
        end else if (cmd.init_en && !stat.init_done) begin
            init_g_reg <= init_g_reg + 1'b1;
            if (init_next == class_count(init_cls_reg)) begin
                init_cls_reg <= init_cls_reg + 1'b1;
                init_loc_reg <= '0;
            end else begin
                init_loc_reg <= init_next;
            end
        end
    end

    // list heads, free counts and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                head_reg[i] <= '0;
                left_reg[i] <= class_count(CLS_W'(i));
            end
        end else if (cmd.commit) begin
            status_reg <= ST_IGNORED;
            baddr_reg  <= '0;
            pidx_reg   <= '0;
            if (op_reg == OP_ALLOC) begin
                priority if (nofit_reg) begin
                    status_reg <= ST_NO_FIT;
                end else if (empty_reg) begin
                    status_reg <= ST_POOL_EMPTY;
                    pidx_reg   <= cls_reg;
                end else begin
                    status_reg        <= ST_ALLOCATED;
                    pidx_reg          <= cls_reg;
                    baddr_reg         <= region_base + ADDR_BITS'(rel_reg);
                    head_reg[cls_reg] <= rdata_reg[LINK_W-1:0];
                    left_reg[cls_reg] <= left_reg[cls_reg] - 1'b1;
                end
            end else begin
                priority if (null_reg || !inrange_reg) begin
                    status_reg <= ST_IGNORED;
                end else if (!aligned) begin
                    status_reg <= ST_MISALIGNED;
                    pidx_reg   <= cls_reg;
                end else if (rdata_reg[LINK_W]) begin
                    status_reg <= ST_DOUBLE;
                    pidx_reg   <= cls_reg;
                end else begin
                    status_reg        <= ST_FREED;
                    pidx_reg          <= cls_reg;
                    head_reg[cls_reg] <= local_reg;
                    left_reg[cls_reg] <= left_reg[cls_reg] + 1'b1;
                end
            end
        end
    end

    assign m_status        = status_reg;
    assign m_block_address = baddr_reg;
    assign m_pool_index    = pidx_reg;

endmodule

/* sv/segregated_pool_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_pool_allocator
// Fixed-block allocator over nine size classes with per-class free lists.
// ----------------------------------------------------------------------------
// After reset the block sets up the free-list link memory (one block a cycle)
// and takes no request until that is done. The region_base register is
// written through the APB port at byte addresses 0 to 7 (paddr[3] low); the
// user must write it only while no request is in flight, as the block itself
// does not enforce this. After the transfer each request steps through offset
// subtract, class and pool lookup, registered link memory read ahead of its
// write, and update with result, which loads the result register. A new
// request is taken as soon as the result register is loaded, so a waiting
// result only holds the block when the next result is due.
module segregated_pool_allocator
    import spa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [SIZE_W-1:0]    s_request_size,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [ADDR_BITS-1:0] m_block_address,
    output logic [CLS_W-1:0]     m_pool_index
);

    logic [ADDR_BITS-1:0] region_base_reg;
    spa_cmd_t             cmd;
    spa_stat_t            stat;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == 1'b0) ? 64'(region_base_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[3] == 1'b0)) begin
            region_base_reg <= pwdata[ADDR_BITS-1:0];
        end
    end

    spa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spa_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .region_base     (region_base_reg),
        .s_operation     (s_operation),
        .s_request_size  (s_request_size),
        .s_address       (s_address),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_pool_index    (m_pool_index)
    );

endmodule

/* tb/sv/segregated_pool_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_pool_allocator_tb
// Drives alloc and free requests through the valid/ready input channel,
// predicts each response with a behavioural free-list model and compares the
// response channel field by field, across several region_base settings.
// ----------------------------------------------------------------------------
module segregated_pool_allocator_tb;
    import spa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                 op;
        logic [SIZE_W-1:0]    size;
        logic [ADDR_BITS-1:0] addr;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic [ADDR_BITS-1:0] blk;
        logic [CLS_W-1:0]     pool;
    } response_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel, penable, pwrite;
    logic [3:0]           paddr;
    logic [63:0]          pwdata;
    logic [63:0]          prdata;
    logic                 pready;
    logic                 s_valid, s_ready, s_operation;
    logic [SIZE_W-1:0]    s_request_size;
    logic [ADDR_BITS-1:0] s_address;
    logic                 m_valid, m_ready;
    logic [2:0]           m_status;
    logic [ADDR_BITS-1:0] m_block_address;
    logic [CLS_W-1:0]     m_pool_index;

    segregated_pool_allocator dut (.*);

    // allocator model state
    logic [ADDR_BITS-1:0] mdl_base;
    int unsigned          mdl_link [TOTAL_BLOCKS];
    bit                   mdl_free [TOTAL_BLOCKS];
    int unsigned          mdl_head [NUM_CLASSES];
    int unsigned          mdl_left [NUM_CLASSES];
    int unsigned          sz_tab   [NUM_CLASSES] = '{16, 32, 64, 128, 256, 512, 1024, 2048, 4480};
    int unsigned          cnt_tab  [NUM_CLASSES] = '{256, 128, 64, 32, 16, 8, 16, 64, 16};
    int unsigned          off_tab  [NUM_CLASSES];
    int unsigned          first_tab[NUM_CLASSES];
    int unsigned          region_len;

    request_t             pending_reqs[$];
    response_t            expected_resps[$];
    logic [ADDR_BITS-1:0] held_blocks[$];

    int  sender_idle_pct, receiver_idle_pct;
    bit  sender_hold;
    int  mismatches;
    int  quiet_cycles;

    function automatic void model_reset();
        int unsigned o, f;
        o = 0;
        f = 0;
        mdl_base = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            off_tab[c]   = o;
            first_tab[c] = f;
            for (int j = 0; j < cnt_tab[c]; j++) begin
                mdl_link[f + j] = j + 1;
                mdl_free[f + j] = 1'b1;
            end
            mdl_head[c] = 0;
            mdl_left[c] = cnt_tab[c];
            o += sz_tab[c] * cnt_tab[c];
            f += cnt_tab[c];
        end
        region_len = o;
    endfunction

    function automatic response_t allocate_or_free(request_t r);
        response_t            res;
        int                   c;
        int unsigned          h, g, loc, lo;
        logic [ADDR_BITS-1:0] off;
        res = '{ST_IGNORED, '0, '0};
        if (r.op == OP_ALLOC) begin
            c = 0;
            while (c < NUM_CLASSES && sz_tab[c] < r.size) c++;
            if (c >= NUM_CLASSES) begin
                res.status = ST_NO_FIT;
                return res;
            end
            res.pool = CLS_W'(c);
            h = mdl_head[c];
            if (mdl_left[c] == 0 || h >= cnt_tab[c]) begin
                res.status = ST_POOL_EMPTY;
                return res;
            end
            g = first_tab[c] + h;
            mdl_head[c] = mdl_link[g];
            mdl_left[c]--;
            mdl_free[g] = 1'b0;
            res.status = ST_ALLOCATED;
            res.blk = mdl_base + ADDR_BITS'(off_tab[c]) + ADDR_BITS'(h * sz_tab[c]);
            return res;
        end
        if (r.addr == '0) return res;
        off = r.addr - mdl_base;
        if (off >= region_len) return res;
        c = 0;
        while (off >= off_tab[c] + sz_tab[c] * cnt_tab[c]) c++;
        res.pool = CLS_W'(c);
        lo = int'(off) - off_tab[c];
        if (lo % sz_tab[c] != 0) begin
            res.status = ST_MISALIGNED;
            return res;
        end
        loc = lo / sz_tab[c];
        g = first_tab[c] + loc;
        if (mdl_free[g]) begin
            res.status = ST_DOUBLE;
            return res;
        end
        mdl_free[g] = 1'b1;
        mdl_link[g] = mdl_head[c];
        mdl_head[c] = loc;
        mdl_left[c]++;
        res.status = ST_FREED;
        return res;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog on transfer activity
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn
            || (pending_reqs.size() == 0 && expected_resps.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() != 0 && !sender_hold
                && $urandom_range(99) >= sender_idle_pct) begin
                request_t r;
                r = pending_reqs.pop_front();
                expected_resps.push_back(allocate_or_free(r));
                s_valid        <= 1'b1;
                s_operation    <= r.op;
                s_request_size <= r.size;
                s_address      <= r.addr;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // response monitor and ready pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response status %0d addr %h pool %0d",
                                 m_status, m_block_address, m_pool_index);
                end else begin
                    response_t e;
                    e = expected_resps.pop_front();
                    if (m_status !== e.status || m_block_address !== e.blk
                        || m_pool_index !== e.pool) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
                                     e.status, e.blk, e.pool,
                                     m_status, m_block_address, m_pool_index);
                    end else if (e.status == ST_ALLOCATED && $urandom_range(99) < 70) begin
                        held_blocks.push_back(e.blk);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic apb_write(input logic [ADDR_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= 64'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mdl_base = value;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_resps.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [ADDR_BITS-1:0] rand48();
        return ADDR_BITS'({$urandom(), $urandom()});
    endfunction

    // mostly legal traffic that recycles handed-out blocks
    task automatic queue_traffic(input int n);
        request_t r;
        int       k, pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            r.op = 1'b0;
            r.size = SIZE_W'($urandom_range(4480));
            r.addr = rand48();
            if (pick < 8) r.size = SIZE_W'($urandom_range(4481, 65535));
            else if (pick < 20) r.size = SIZE_W'(rand48());
            if (pick >= 45 && pick < 85 && held_blocks.size() != 0) begin
                k = $urandom_range(held_blocks.size() - 1);
                r.op = 1'b1;
                r.addr = held_blocks[k];
                held_blocks.delete(k);
            end else if (pick >= 85 && pick < 90) begin
                r.op = 1'b1;
                r.addr = mdl_base + ADDR_BITS'($urandom_range(region_len - 1));
            end else if (pick >= 90 && pick < 95) begin
                r.op = 1'b1;
                r.addr = mdl_base + ADDR_BITS'(16 * $urandom_range(256));
            end else if (pick >= 95) begin
                r.op = 1'b1;
                if (pick == 99) r.addr = '0;
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial begin
        request_t r;
        mismatches = 0;
        quiet_cycles = 0;
        sender_hold = 1'b0;
        sender_idle_pct = 22;
        receiver_idle_pct = 62;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_operation = 1'b0; s_request_size = '0; s_address = '0;
        m_ready = 1'b0;
        model_reset();
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: size extremes, null, foreign, misaligned, double free
        apb_write(48'h0000_0001_0000);
        foreach (sz_tab[c]) pending_reqs.push_back('{1'b0, SIZE_W'(sz_tab[c]), '0});
        pending_reqs.push_back('{1'b0, 16'd0, '0});
        pending_reqs.push_back('{1'b0, 16'd4481, '0});
        pending_reqs.push_back('{1'b0, 16'hFFFF, '0});
        pending_reqs.push_back('{1'b1, 16'hFFFF, '0});
        pending_reqs.push_back('{1'b1, '0, 48'hFFFF_FFFF_FFFF});
        pending_reqs.push_back('{1'b1, '0, 48'h0000_0001_0008});
        pending_reqs.push_back('{1'b1, '0, 48'h0000_0001_0000});
        pending_reqs.push_back('{1'b1, '0, 48'h0000_0001_0000});
        pending_reqs.push_back('{1'b1, '0, 48'h0000_0001_0000 + 243712});
        pending_reqs.push_back('{1'b1, '0, 48'h0000_0001_0000 + 172032 + 4480});
        // drain class 5 to reach an empty pool
        repeat (9) pending_reqs.push_back('{1'b0, 16'd400, '0});
        wait_drained();

        // region wrapping past the top of the address space
        apb_write(48'hFFFF_FFFF_0000);
        queue_traffic(500);
        wait_drained();

        sender_idle_pct = 62;
        receiver_idle_pct = 22;
        apb_write(rand48());
        queue_traffic(300);
        // sender pauses until every response is back
        sender_hold = 1'b1;
        while (expected_resps.size() != 0) @(posedge aclk);
        sender_hold = 1'b0;
        queue_traffic(200);
        wait_drained();

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        apb_write(48'h0);
        queue_traffic(300);
        wait_drained();
        apb_write(48'hFFFF_FFFF_FFFF);
        queue_traffic(250);
        wait_drained();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
sv/spa_pkg.sv
sv/spa_ctrl.sv
sv/spa_dpath.sv
sv/segregated_pool_allocator.sv
tb/sv/segregated_pool_allocator_tb.sv
